FILE: design/sbpci_pkg.sv
// Package with types, codes and byte tables of the south bridge configuration space.
package sbpci_pkg;

  localparam int unsigned FN_W   = 3;
  localparam int unsigned OFF_W  = 8;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ADDR_W = 10;

  localparam logic [1:0] FN_BRIDGE = 2'd0;
  localparam logic [1:0] FN_IDE    = 2'd1;
  localparam logic [1:0] FN_USB    = 2'd2;
  localparam logic [1:0] FN_POWER  = 2'd3;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  function automatic logic [BYTE_W-1:0] reset_byte(logic [1:0] fn, logic [OFF_W-1:0] off);
    logic [BYTE_W-1:0] b;
    b = '0;
    unique case (fn)
      FN_BRIDGE: begin
        case (off)
          8'h00: b = 8'h06; 8'h01: b = 8'h11; 8'h02: b = 8'h86; 8'h03: b = 8'h05;
          8'h04: b = 8'h0f; 8'h07: b = 8'h02; 8'h0a: b = 8'h01; 8'h0b: b = 8'h06;
          8'h0e: b = 8'h80; 8'h48: b = 8'h01; 8'h4a: b = 8'h04; 8'h4f: b = 8'h03;
          8'h50: b = 8'h24; 8'h59: b = 8'h04;
          default: b = '0;
        endcase
      end
      FN_IDE: begin
        case (off)
          8'h00: b = 8'h06; 8'h01: b = 8'h11; 8'h02: b = 8'h71; 8'h03: b = 8'h05;
          8'h04: b = 8'h80; 8'h06: b = 8'h80; 8'h07: b = 8'h02; 8'h09: b = 8'h85;
          8'h0a: b = 8'h01; 8'h0b: b = 8'h01; 8'h10: b = 8'hf1; 8'h11: b = 8'h01;
          8'h14: b = 8'hf5; 8'h15: b = 8'h03; 8'h18: b = 8'h71; 8'h19: b = 8'h01;
          8'h1c: b = 8'h75; 8'h1d: b = 8'h03; 8'h20: b = 8'h01; 8'h21: b = 8'hcc;
          8'h3c: b = 8'h0e; 8'h40: b = 8'h08; 8'h41: b = 8'h02; 8'h42: b = 8'h09;
          8'h43: b = 8'h3a; 8'h44: b = 8'h68; 8'h46: b = 8'hc0; 8'h48: b = 8'ha8;
          8'h49: b = 8'ha8; 8'h4a: b = 8'ha8; 8'h4b: b = 8'ha8; 8'h4c: b = 8'hff;
          8'h4e: b = 8'hff; 8'h4f: b = 8'hff; 8'h50: b = 8'h03; 8'h51: b = 8'h03;
          8'h52: b = 8'h03; 8'h53: b = 8'h03; 8'h61: b = 8'h02; 8'h68: b = 8'h02;
          default: b = '0;
        endcase
      end
      FN_USB: begin
        case (off)
          8'h00: b = 8'h06; 8'h01: b = 8'h11; 8'h02: b = 8'h38; 8'h03: b = 8'h30;
          8'h07: b = 8'h02; 8'h0a: b = 8'h03; 8'h0b: b = 8'h0c; 8'h0d: b = 8'h16;
          8'h20: b = 8'h01; 8'h21: b = 8'h03; 8'h3d: b = 8'h04; 8'h60: b = 8'h10;
          8'hc1: b = 8'h20;
          default: b = '0;
        endcase
      end
      FN_POWER: begin
        case (off)
          8'h00: b = 8'h06; 8'h01: b = 8'h11; 8'h02: b = 8'h40; 8'h03: b = 8'h30;
          8'h06: b = 8'h80; 8'h07: b = 8'h02; 8'h08: b = 8'h10; 8'h48: b = 8'h01;
          default: b = '0;
        endcase
      end
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic write_locked(logic [1:0] fn, logic [OFF_W-1:0] a);
    logic lk;
    lk = 1'b1;
    unique case (fn)
      FN_BRIDGE: lk = (a < 8'h04) || (a == 8'h05) || (a == 8'h06) ||
                      (a >= 8'h08 && a <= 8'h3f) || (a == 8'h49) || (a == 8'h4b) ||
                      (a >= 8'h51 && a <= 8'h53) || (a >= 8'h5d && a <= 8'h5f) ||
                      (a >= 8'h68 && a <= 8'h69) || (a >= 8'h71);
      FN_IDE:    lk = (a < 8'h04) || (a == 8'h05) || (a == 8'h08) ||
                      (a >= 8'h0a && a <= 8'h0c) || (a >= 8'h0e && a <= 8'h1f) ||
                      (a >= 8'h22 && a <= 8'h3b) || (a >= 8'h3d && a <= 8'h3f) ||
                      (a >= 8'h52);
      FN_USB:    lk = (a < 8'h04) || (a == 8'h05) || (a == 8'h06) ||
                      (a >= 8'h08 && a <= 8'h0c) || (a >= 8'h0e && a <= 8'h1f) ||
                      (a >= 8'h22 && a <= 8'h3b) || (a >= 8'h3e && a <= 8'h3f) ||
                      (a >= 8'h42 && a <= 8'h43) || (a >= 8'h46 && a <= 8'hbf) ||
                      (a >= 8'hc2);
      FN_POWER:  lk = (a < 8'h0d) || (a >= 8'h0e && a <= 8'h3f) || (a == 8'h43) ||
                      (a == 8'h48) || (a >= 8'h4a && a <= 8'h4f) || (a >= 8'h54);
      default:   lk = 1'b1;
    endcase
    return lk;
  endfunction

  // The IDE programming interface byte copies bridge register 9, which is read-only
  // and always zero, so a write to it always stores 0x8A.
  function automatic logic [BYTE_W-1:0] write_byte(logic [1:0] fn, logic [OFF_W-1:0] a,
                                                   logic [BYTE_W-1:0] v,
                                                   logic [BYTE_W-1:0] old);
    logic [BYTE_W-1:0] b;
    b = v;
    unique case (fn)
      FN_BRIDGE: begin
        if (a == 8'h04) b = (v & 8'h08) | 8'h07;
        else if (a == 8'h47) b = v & 8'hfe;
      end
      FN_IDE: begin
        if (a == 8'h04) b = v & 8'h85;
        else if (a == 8'h06) b = old & ~(v & 8'hb0);
        else if (a == 8'h09) b = (reset_byte(FN_BRIDGE, 8'h09) & 8'h8f) | 8'h8a;
        else if (a == 8'h20) b = (v & 8'hf0) | 8'h01;
      end
      FN_USB: begin
        if (a == 8'h04) b = v & 8'h97;
        else if (a == 8'h07) b = v & 8'h7f;
        else if (a == 8'h20) b = (v & 8'he0) | 8'h01;
      end
      default: b = v;
    endcase
    return b;
  endfunction

endpackage

FILE: design/southbridge_pci_config_space.sv
// Top level of the south bridge PCI configuration space with its byte memory.
//
// The input stream carries one configuration access per word: in_tuser is the
// operation (0 read, 1 write) and in_tdata holds function, offset and write byte.
// The output stream returns one word per access with the byte read, the reset
// pulse flag and the decoded routing, I/O bases and enables after that access.
// All four functions live in one 1024 x 8 memory with a registered read port.
// An access reads its byte in the accept cycle and writes the filtered byte back
// in the EXEC state that follows, once the output register is free; the output
// word is registered at that write-back. No new access is taken until the
// read-modify-write of the last one is done, but one is taken while a finished
// word still waits; the write-back of that access waits until the output
// register is free, so a stalled receiver stalls the input after one more word.
// After reset a clearing pass loads the default bytes into all 1024 memory
// locations, one byte a cycle; in_tready stays low during that pass.
module southbridge_pci_config_space (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // function[2:0], register_offset[10:3], write_data[18:11]
  input  logic        in_tuser,   // operation[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_data[7:0], reset_request[8], route_inta[12:9], route_intb[16:13],
  // route_intc[20:17], route_intd[24:21], busmaster_base[40:25],
  // usb_io_base[56:41], acpi_io_base[72:57], decode_enables[75:73],
  // ide_channel_enables[77:76]
  output logic [79:0] out_tdata
);

  localparam int unsigned AW = sbpci_pkg::ADDR_W;
  localparam int unsigned BW = sbpci_pkg::BYTE_W;
  localparam int unsigned DEPTH = 1 << AW;

  localparam logic [AW-1:0] A_BR55  = {sbpci_pkg::FN_BRIDGE, 8'h55};
  localparam logic [AW-1:0] A_BR56  = {sbpci_pkg::FN_BRIDGE, 8'h56};
  localparam logic [AW-1:0] A_BR57  = {sbpci_pkg::FN_BRIDGE, 8'h57};
  localparam logic [AW-1:0] A_IDE04 = {sbpci_pkg::FN_IDE, 8'h04};
  localparam logic [AW-1:0] A_IDE20 = {sbpci_pkg::FN_IDE, 8'h20};
  localparam logic [AW-1:0] A_IDE21 = {sbpci_pkg::FN_IDE, 8'h21};
  localparam logic [AW-1:0] A_IDE40 = {sbpci_pkg::FN_IDE, 8'h40};
  localparam logic [AW-1:0] A_USB04 = {sbpci_pkg::FN_USB, 8'h04};
  localparam logic [AW-1:0] A_USB20 = {sbpci_pkg::FN_USB, 8'h20};
  localparam logic [AW-1:0] A_USB21 = {sbpci_pkg::FN_USB, 8'h21};
  localparam logic [AW-1:0] A_PM41  = {sbpci_pkg::FN_POWER, 8'h41};
  localparam logic [AW-1:0] A_PM49  = {sbpci_pkg::FN_POWER, 8'h49};

  logic [BW-1:0] mem [DEPTH];
  logic [BW-1:0] mem_rdata_r;
  logic          mem_re;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [BW-1:0] mem_wdata;

  sbpci_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;

  logic          op_r;
  logic [2:0]    fn_r;
  logic [7:0]    off_r;
  logic [7:0]    wd_r;

  logic          out_tvalid_r;
  logic [BW-1:0] out_rd_r;
  logic          out_rst_r;

  logic [BW-1:0] br55_r, br56_r, br57_r;
  logic [BW-1:0] ide04_r, ide20_r, ide21_r, ide40_r;
  logic [BW-1:0] usb04_r, usb20_r, usb21_r;
  logic [BW-1:0] pm41_r, pm49_r;

  logic          in_fire;
  logic          exec_go;
  logic          wr_ok;
  logic [AW-1:0] item_addr;
  logic [BW-1:0] wr_byte;
  logic [BW-1:0] rd_byte;
  logic          pulse;

  assign in_fire   = in_tvalid && in_tready;
  assign item_addr = {fn_r[1:0], off_r};
  assign wr_byte   = sbpci_pkg::write_byte(fn_r[1:0], off_r, wd_r, mem_rdata_r);
  assign wr_ok     = (op_r == sbpci_pkg::OP_WRITE) && !fn_r[2] &&
                     !sbpci_pkg::write_locked(fn_r[1:0], off_r);
  assign rd_byte   = (op_r == sbpci_pkg::OP_WRITE) ? '0 :
                     (fn_r[2] ? 8'hff : mem_rdata_r);
  assign pulse     = wr_ok && (fn_r[1:0] == sbpci_pkg::FN_BRIDGE) && (off_r == 8'h47) &&
                     wd_r[7] && wd_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbpci_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = item_addr;
    mem_wdata = wr_byte;
    exec_go   = 1'b0;
    unique case (state_r)
      sbpci_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = sbpci_pkg::reset_byte(clr_cnt_r[AW-1:AW-2], clr_cnt_r[AW-3:0]);
        if (clr_cnt_r == {AW{1'b1}}) state_nxt = sbpci_pkg::ST_IDLE;
      end
      sbpci_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          mem_re    = 1'b1;
          state_nxt = sbpci_pkg::ST_EXEC;
        end
      end
      sbpci_pkg::ST_EXEC: begin
        if (!out_tvalid_r || out_tready) begin
          exec_go   = 1'b1;
          mem_we    = wr_ok;
          state_nxt = sbpci_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sbpci_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_r <= mem[{in_tdata[1:0], in_tdata[10:3]}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (state_r == sbpci_pkg::ST_CLEAR) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_tuser;
      fn_r  <= in_tdata[2:0];
      off_r <= in_tdata[10:3];
      wd_r  <= in_tdata[18:11];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (exec_go) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_rd_r  <= rd_byte;
      out_rst_r <= pulse;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      br55_r  <= sbpci_pkg::reset_byte(sbpci_pkg::FN_BRIDGE, 8'h55);
      br56_r  <= sbpci_pkg::reset_byte(sbpci_pkg::FN_BRIDGE, 8'h56);
      br57_r  <= sbpci_pkg::reset_byte(sbpci_pkg::FN_BRIDGE, 8'h57);
      ide04_r <= sbpci_pkg::reset_byte(sbpci_pkg::FN_IDE, 8'h04);
      ide20_r <= sbpci_pkg::reset_byte(sbpci_pkg::FN_IDE, 8'h20);
      ide21_r <= sbpci_pkg::reset_byte(sbpci_pkg::FN_IDE, 8'h21);
      ide40_r <= sbpci_pkg::reset_byte(sbpci_pkg::FN_IDE, 8'h40);
      usb04_r <= sbpci_pkg::reset_byte(sbpci_pkg::FN_USB, 8'h04);
      usb20_r <= sbpci_pkg::reset_byte(sbpci_pkg::FN_USB, 8'h20);
      usb21_r <= sbpci_pkg::reset_byte(sbpci_pkg::FN_USB, 8'h21);
      pm41_r  <= sbpci_pkg::reset_byte(sbpci_pkg::FN_POWER, 8'h41);
      pm49_r  <= sbpci_pkg::reset_byte(sbpci_pkg::FN_POWER, 8'h49);
    end else if (exec_go && wr_ok) begin
      if (item_addr == A_BR55)  br55_r  <= wr_byte;
      if (item_addr == A_BR56)  br56_r  <= wr_byte;
      if (item_addr == A_BR57)  br57_r  <= wr_byte;
      if (item_addr == A_IDE04) ide04_r <= wr_byte;
      if (item_addr == A_IDE20) ide20_r <= wr_byte;
      if (item_addr == A_IDE21) ide21_r <= wr_byte;
      if (item_addr == A_IDE40) ide40_r <= wr_byte;
      if (item_addr == A_USB04) usb04_r <= wr_byte;
      if (item_addr == A_USB20) usb20_r <= wr_byte;
      if (item_addr == A_USB21) usb21_r <= wr_byte;
      if (item_addr == A_PM41)  pm41_r  <= wr_byte;
      if (item_addr == A_PM49)  pm49_r  <= wr_byte;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00,
                       ide04_r[0] & ide40_r[0], ide04_r[0] & ide40_r[1],
                       pm41_r[7], usb04_r[0], ide04_r[0],
                       pm49_r, 8'h00,
                       usb21_r, usb20_r[7:5], 5'b00000,
                       ide21_r, ide20_r[7:4], 4'b0000,
                       br55_r[7:4], br57_r[7:4], br56_r[3:0], br56_r[7:4],
                       out_rst_r, out_rd_r};

endmodule

FILE: design/sbpci_chk.sv
// Port-level checker for the south bridge configuration space, bound to the top level.
module sbpci_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("Output word dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("Output word changed while stalled.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Second access taken while one is in progress.");

  a_pulse_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> out_tdata[7:0] == 8'h00)
    else $error("Reset pulse reported on a read access.");

  a_channel_needs_decode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[77] || out_tdata[76]) |-> out_tdata[73])
    else $error("IDE channel enabled without bus master decode.");

endmodule

bind southbridge_pci_config_space sbpci_chk u_sbpci_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the south bridge PCI configuration space.
`timescale 1ns / 100ps

module testbench;

  localparam logic [sbpci_pkg::FN_W-1:0] F_BRIDGE = {1'b0, sbpci_pkg::FN_BRIDGE};
  localparam logic [sbpci_pkg::FN_W-1:0] F_IDE    = {1'b0, sbpci_pkg::FN_IDE};
  localparam logic [sbpci_pkg::FN_W-1:0] F_USB    = {1'b0, sbpci_pkg::FN_USB};
  localparam logic [sbpci_pkg::FN_W-1:0] F_POWER  = {1'b0, sbpci_pkg::FN_POWER};
  localparam logic [sbpci_pkg::FN_W-1:0] F_ABSENT_LO = 3'd4;
  localparam logic [sbpci_pkg::FN_W-1:0] F_ABSENT_MID = 3'd6;
  localparam logic [sbpci_pkg::FN_W-1:0] F_ABSENT_HI = 3'd7;

  localparam logic [sbpci_pkg::OFF_W-1:0] REG_VENDOR_LO  = 8'h00;
  localparam logic [sbpci_pkg::OFF_W-1:0] REG_COMMAND    = 8'h04;
  localparam logic [sbpci_pkg::OFF_W-1:0] REG_STATUS_LO  = 8'h06;
  localparam logic [sbpci_pkg::OFF_W-1:0] REG_STATUS_HI  = 8'h07;
  localparam logic [sbpci_pkg::OFF_W-1:0] REG_PROG_IF    = 8'h09;
  localparam logic [sbpci_pkg::OFF_W-1:0] REG_LATENCY    = 8'h0d;
  localparam logic [sbpci_pkg::OFF_W-1:0] REG_BAR4_LO    = 8'h20;
  localparam logic [sbpci_pkg::OFF_W-1:0] REG_BAR4_HI    = 8'h21;
  localparam logic [sbpci_pkg::OFF_W-1:0] REG_INT_LINE   = 8'h3c;
  localparam logic [sbpci_pkg::OFF_W-1:0] REG_INT_PIN    = 8'h3d;
  localparam logic [sbpci_pkg::OFF_W-1:0] REG_IDE_CHAN   = 8'h40;
  localparam logic [sbpci_pkg::OFF_W-1:0] REG_PM_CTRL    = 8'h41;
  localparam logic [sbpci_pkg::OFF_W-1:0] REG_BR_RESET   = 8'h47;
  localparam logic [sbpci_pkg::OFF_W-1:0] REG_PM_IOBASE  = 8'h49;
  localparam logic [sbpci_pkg::OFF_W-1:0] REG_PIRQ_D     = 8'h55;
  localparam logic [sbpci_pkg::OFF_W-1:0] REG_PIRQ_AB    = 8'h56;
  localparam logic [sbpci_pkg::OFF_W-1:0] REG_PIRQ_C     = 8'h57;
  localparam logic [sbpci_pkg::OFF_W-1:0] REG_USB_LEGACY = 8'hc0;
  localparam logic [sbpci_pkg::OFF_W-1:0] REG_USB_LEG_HI = 8'hc1;
  localparam logic [sbpci_pkg::OFF_W-1:0] REG_TOP        = 8'hff;

  localparam int DIRECTED_ROWS   = 27;
  localparam int RANDOM_ACCESSES = 1700;
  localparam int LONG_HOLD       = 400;
  localparam int IDLE_LIMIT      = 5000;
  localparam int TAIL_CYCLES     = 16;

  typedef struct packed {
    logic                         op;
    logic [sbpci_pkg::FN_W-1:0]   fn;
    logic [sbpci_pkg::OFF_W-1:0]  off;
    logic [sbpci_pkg::BYTE_W-1:0] data;
  } cfg_access_t;

  typedef struct packed {
    logic [1:0]                   ide_channel_enables;
    logic [2:0]                   decode_enables;
    logic [15:0]                  acpi_io_base;
    logic [15:0]                  usb_io_base;
    logic [15:0]                  busmaster_base;
    logic [3:0]                   route_intd;
    logic [3:0]                   route_intc;
    logic [3:0]                   route_intb;
    logic [3:0]                   route_inta;
    logic                         reset_request;
    logic [sbpci_pkg::BYTE_W-1:0] read_data;
  } cfg_reply_t;

  typedef struct {
    cfg_access_t                  acc;
    logic                         fixed;
    logic [sbpci_pkg::BYTE_W-1:0] fixed_rd;
  } cfg_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // function[2:0], register_offset[10:3], write_data[18:11]
  logic        in_tuser = 1'b0; // operation[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;       // read_data[7:0] up to ide_channel_enables[77:76]

  logic [sbpci_pkg::BYTE_W-1:0] bridge_bytes [0:255];
  logic [sbpci_pkg::BYTE_W-1:0] ide_bytes    [0:255];
  logic [sbpci_pkg::BYTE_W-1:0] usb_bytes    [0:255];
  logic [sbpci_pkg::BYTE_W-1:0] pm_bytes     [0:255];

  cfg_reply_t cfg_replies_due [$];

  int errors = 0;
  int replies_checked = 0;
  int reads_sent = 0;
  int writes_sent = 0;
  int absent_sent = 0;
  int pulses_due = 0;
  int burst_left = 0;
  bit long_hold_done = 1'b0;

  southbridge_pci_config_space u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic load_cfg_defaults();
    for (int i = 0; i < 256; i++) begin
      bridge_bytes[i] = 8'h00;
      ide_bytes[i]    = 8'h00;
      usb_bytes[i]    = 8'h00;
      pm_bytes[i]     = 8'h00;
    end
    bridge_bytes[8'h00] = 8'h06; bridge_bytes[8'h01] = 8'h11;
    bridge_bytes[8'h02] = 8'h86; bridge_bytes[8'h03] = 8'h05;
    bridge_bytes[8'h04] = 8'h0f; bridge_bytes[8'h07] = 8'h02;
    bridge_bytes[8'h0a] = 8'h01; bridge_bytes[8'h0b] = 8'h06;
    bridge_bytes[8'h0e] = 8'h80; bridge_bytes[8'h48] = 8'h01;
    bridge_bytes[8'h4a] = 8'h04; bridge_bytes[8'h4f] = 8'h03;
    bridge_bytes[8'h50] = 8'h24; bridge_bytes[8'h59] = 8'h04;

    ide_bytes[8'h00] = 8'h06; ide_bytes[8'h01] = 8'h11;
    ide_bytes[8'h02] = 8'h71; ide_bytes[8'h03] = 8'h05;
    ide_bytes[8'h04] = 8'h80; ide_bytes[8'h06] = 8'h80; ide_bytes[8'h07] = 8'h02;
    ide_bytes[8'h09] = 8'h85; ide_bytes[8'h0a] = 8'h01; ide_bytes[8'h0b] = 8'h01;
    ide_bytes[8'h10] = 8'hf1; ide_bytes[8'h11] = 8'h01;
    ide_bytes[8'h14] = 8'hf5; ide_bytes[8'h15] = 8'h03;
    ide_bytes[8'h18] = 8'h71; ide_bytes[8'h19] = 8'h01;
    ide_bytes[8'h1c] = 8'h75; ide_bytes[8'h1d] = 8'h03;
    ide_bytes[8'h20] = 8'h01; ide_bytes[8'h21] = 8'hcc;
    ide_bytes[8'h3c] = 8'h0e;
    ide_bytes[8'h40] = 8'h08; ide_bytes[8'h41] = 8'h02;
    ide_bytes[8'h42] = 8'h09; ide_bytes[8'h43] = 8'h3a;
    ide_bytes[8'h44] = 8'h68; ide_bytes[8'h46] = 8'hc0;
    ide_bytes[8'h48] = 8'ha8; ide_bytes[8'h49] = 8'ha8;
    ide_bytes[8'h4a] = 8'ha8; ide_bytes[8'h4b] = 8'ha8;
    ide_bytes[8'h4c] = 8'hff; ide_bytes[8'h4e] = 8'hff; ide_bytes[8'h4f] = 8'hff;
    ide_bytes[8'h50] = 8'h03; ide_bytes[8'h51] = 8'h03;
    ide_bytes[8'h52] = 8'h03; ide_bytes[8'h53] = 8'h03;
    ide_bytes[8'h61] = 8'h02; ide_bytes[8'h68] = 8'h02;

    usb_bytes[8'h00] = 8'h06; usb_bytes[8'h01] = 8'h11;
    usb_bytes[8'h02] = 8'h38; usb_bytes[8'h03] = 8'h30;
    usb_bytes[8'h07] = 8'h02; usb_bytes[8'h0a] = 8'h03;
    usb_bytes[8'h0b] = 8'h0c; usb_bytes[8'h0d] = 8'h16;
    usb_bytes[8'h20] = 8'h01; usb_bytes[8'h21] = 8'h03;
    usb_bytes[8'h3d] = 8'h04; usb_bytes[8'h60] = 8'h10;
    usb_bytes[8'hc1] = 8'h20;

    pm_bytes[8'h00] = 8'h06; pm_bytes[8'h01] = 8'h11;
    pm_bytes[8'h02] = 8'h40; pm_bytes[8'h03] = 8'h30;
    pm_bytes[8'h06] = 8'h80; pm_bytes[8'h07] = 8'h02;
    pm_bytes[8'h08] = 8'h10; pm_bytes[8'h48] = 8'h01;
  endtask

  function automatic logic byte_writable(logic [1:0] fn,
                                         logic [sbpci_pkg::OFF_W-1:0] a);
    logic ok;
    ok = 1'b0;
    case (fn)
      sbpci_pkg::FN_BRIDGE:
        ok = (a == 8'h04) || (a == 8'h07) || (a >= 8'h40 && a <= 8'h48) ||
             (a == 8'h4a) || (a >= 8'h4c && a <= 8'h50) ||
             (a >= 8'h54 && a <= 8'h5c) || (a >= 8'h60 && a <= 8'h67) ||
             (a >= 8'h6a && a <= 8'h70);
      sbpci_pkg::FN_IDE:
        ok = (a == 8'h04) || (a == 8'h06) || (a == 8'h07) || (a == 8'h09) ||
             (a == 8'h0d) || (a == 8'h20) || (a == 8'h21) || (a == 8'h3c) ||
             (a >= 8'h40 && a <= 8'h51);
      sbpci_pkg::FN_USB:
        ok = (a == 8'h04) || (a == 8'h07) || (a == 8'h0d) || (a == 8'h20) ||
             (a == 8'h21) || (a == 8'h3c) || (a == 8'h3d) || (a == 8'h40) ||
             (a == 8'h41) || (a == 8'h44) || (a == 8'h45) || (a == 8'hc0) ||
             (a == 8'hc1);
      default:
        ok = (a == 8'h0d) || (a >= 8'h40 && a <= 8'h42) ||
             (a >= 8'h44 && a <= 8'h47) || (a == 8'h49) ||
             (a >= 8'h50 && a <= 8'h53);
    endcase
    return ok;
  endfunction

  task automatic perform_cfg_access(input cfg_access_t a, output cfg_reply_t r);
    logic [sbpci_pkg::BYTE_W-1:0] rd;
    logic                         pulse;
    logic                         ide_on;
    rd = 8'h00;
    pulse = 1'b0;
    if (a.fn[2]) begin
      if (a.op == sbpci_pkg::OP_READ) rd = 8'hff;
    end else if (a.op == sbpci_pkg::OP_READ) begin
      case (a.fn[1:0])
        sbpci_pkg::FN_BRIDGE: rd = bridge_bytes[a.off];
        sbpci_pkg::FN_IDE:    rd = ide_bytes[a.off];
        sbpci_pkg::FN_USB:    rd = usb_bytes[a.off];
        default:              rd = pm_bytes[a.off];
      endcase
    end else if (byte_writable(a.fn[1:0], a.off)) begin
      case (a.fn[1:0])
        sbpci_pkg::FN_BRIDGE: begin
          if (a.off == REG_COMMAND) begin
            bridge_bytes[a.off] = {4'b0000, a.data[3], 3'b111};
          end else if (a.off == REG_BR_RESET) begin
            bridge_bytes[a.off] = {a.data[7:1], 1'b0};
            pulse = a.data[7] & a.data[0];
          end else begin
            bridge_bytes[a.off] = a.data;
          end
        end
        sbpci_pkg::FN_IDE: begin
          case (a.off)
            REG_COMMAND:   ide_bytes[a.off] = {a.data[7], 4'b0000, a.data[2], 1'b0, a.data[0]};
            REG_STATUS_LO: ide_bytes[a.off] = ide_bytes[a.off] & ~(a.data & 8'hb0);
            REG_PROG_IF:   ide_bytes[a.off] = (bridge_bytes[REG_PROG_IF] & 8'h8f) | 8'h8a;
            REG_BAR4_LO:   ide_bytes[a.off] = {a.data[7:4], 4'b0001};
            default:       ide_bytes[a.off] = a.data;
          endcase
        end
        sbpci_pkg::FN_USB: begin
          case (a.off)
            REG_COMMAND:   usb_bytes[a.off] = a.data & 8'h97;
            REG_STATUS_HI: usb_bytes[a.off] = {1'b0, a.data[6:0]};
            REG_BAR4_LO:   usb_bytes[a.off] = {a.data[7:5], 5'b00001};
            default:       usb_bytes[a.off] = a.data;
          endcase
        end
        default: pm_bytes[a.off] = a.data;
      endcase
    end

    ide_on = ide_bytes[REG_COMMAND][0];
    r.read_data           = rd;
    r.reset_request       = pulse;
    r.route_inta          = bridge_bytes[REG_PIRQ_AB][7:4];
    r.route_intb          = bridge_bytes[REG_PIRQ_AB][3:0];
    r.route_intc          = bridge_bytes[REG_PIRQ_C][7:4];
    r.route_intd          = bridge_bytes[REG_PIRQ_D][7:4];
    r.busmaster_base      = {ide_bytes[REG_BAR4_HI], ide_bytes[REG_BAR4_LO][7:4], 4'b0000};
    r.usb_io_base         = {usb_bytes[REG_BAR4_HI], usb_bytes[REG_BAR4_LO][7:5], 5'b00000};
    r.acpi_io_base        = {pm_bytes[REG_PM_IOBASE], 8'h00};
    r.decode_enables      = {pm_bytes[REG_PM_CTRL][7], usb_bytes[REG_COMMAND][0], ide_on};
    r.ide_channel_enables = {ide_on & ide_bytes[REG_IDE_CHAN][0],
                             ide_on & ide_bytes[REG_IDE_CHAN][1]};
  endtask

  function automatic logic [sbpci_pkg::OFF_W-1:0] pick_hot_offset();
    logic [sbpci_pkg::OFF_W-1:0] a;
    case ($urandom_range(0, 19))
      0:       a = REG_VENDOR_LO;
      1:       a = REG_COMMAND;
      2:       a = REG_STATUS_LO;
      3:       a = REG_STATUS_HI;
      4:       a = REG_PROG_IF;
      5:       a = REG_LATENCY;
      6:       a = REG_BAR4_LO;
      7:       a = REG_BAR4_HI;
      8:       a = REG_INT_LINE;
      9:       a = REG_INT_PIN;
      10:      a = REG_IDE_CHAN;
      11:      a = REG_PM_CTRL;
      12:      a = REG_BR_RESET;
      13:      a = REG_PM_IOBASE;
      14:      a = REG_PIRQ_D;
      15:      a = REG_PIRQ_AB;
      16:      a = REG_PIRQ_C;
      17:      a = REG_USB_LEGACY;
      18:      a = REG_USB_LEG_HI;
      default: a = REG_TOP;
    endcase
    return a;
  endfunction

  task automatic issue_access(input cfg_access_t acc, input logic fixed,
                              input logic [sbpci_pkg::BYTE_W-1:0] fixed_rd);
    cfg_reply_t  r;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b00000, acc.data, acc.off, acc.fn};
    in_tuser  <= acc.op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    perform_cfg_access(acc, r);
    if (fixed) r.read_data = fixed_rd;
    cfg_replies_due.push_back(r);
    if (acc.op == sbpci_pkg::OP_READ) reads_sent++;
    else writes_sent++;
    if (acc.fn[2]) absent_sent++;
    if (r.reset_request) pulses_due++;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    cfg_reply_t want;
    cfg_reply_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = cfg_reply_t'(out_tdata[77:0]);
      if (cfg_replies_due.size() == 0) begin
        errors++;
        $display("%0t: word with no access pending, expected none, actual 0x%0h",
                 $time, out_tdata);
      end else begin
        want = cfg_replies_due.pop_front();
        check_field("read_data", want.read_data, got.read_data);
        check_field("reset_request", want.reset_request, got.reset_request);
        check_field("route_inta", want.route_inta, got.route_inta);
        check_field("route_intb", want.route_intb, got.route_intb);
        check_field("route_intc", want.route_intc, got.route_intc);
        check_field("route_intd", want.route_intd, got.route_intd);
        check_field("busmaster_base", want.busmaster_base, got.busmaster_base);
        check_field("usb_io_base", want.usb_io_base, got.usb_io_base);
        check_field("acpi_io_base", want.acpi_io_base, got.acpi_io_base);
        check_field("decode_enables", want.decode_enables, got.decode_enables);
        check_field("ide_channel_enables", want.ide_channel_enables,
                    got.ide_channel_enables);
        replies_checked++;
      end
    end
  end

  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    mode = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && replies_checked >= 60) begin
        long_hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(8, 80);
      end
      span--;
      case (mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    cfg_row_t    rows [DIRECTED_ROWS];
    cfg_access_t acc;
    rows = '{
      '{'{sbpci_pkg::OP_READ,  F_BRIDGE,     REG_VENDOR_LO,  8'h00}, 1'b1, 8'h06},
      '{'{sbpci_pkg::OP_READ,  F_IDE,        REG_PROG_IF,    8'h00}, 1'b1, 8'h85},
      '{'{sbpci_pkg::OP_READ,  F_USB,        REG_USB_LEG_HI, 8'h00}, 1'b1, 8'h20},
      '{'{sbpci_pkg::OP_READ,  F_POWER,      REG_TOP,        8'hff}, 1'b1, 8'h00},
      '{'{sbpci_pkg::OP_READ,  F_ABSENT_HI,  REG_TOP,        8'h00}, 1'b1, 8'hff},
      '{'{sbpci_pkg::OP_READ,  F_ABSENT_LO,  REG_VENDOR_LO,  8'h00}, 1'b1, 8'hff},
      '{'{sbpci_pkg::OP_WRITE, F_BRIDGE,     REG_VENDOR_LO,  8'hff}, 1'b1, 8'h00},
      '{'{sbpci_pkg::OP_READ,  F_BRIDGE,     REG_VENDOR_LO,  8'h00}, 1'b1, 8'h06},
      '{'{sbpci_pkg::OP_WRITE, F_BRIDGE,     REG_BR_RESET,   8'hff}, 1'b0, 8'h00},
      '{'{sbpci_pkg::OP_WRITE, F_BRIDGE,     REG_BR_RESET,   8'h01}, 1'b0, 8'h00},
      '{'{sbpci_pkg::OP_WRITE, F_BRIDGE,     REG_COMMAND,    8'h00}, 1'b0, 8'h00},
      '{'{sbpci_pkg::OP_WRITE, F_BRIDGE,     REG_PIRQ_AB,    8'ha5}, 1'b0, 8'h00},
      '{'{sbpci_pkg::OP_WRITE, F_BRIDGE,     REG_PIRQ_C,     8'hf0}, 1'b0, 8'h00},
      '{'{sbpci_pkg::OP_WRITE, F_BRIDGE,     REG_PIRQ_D,     8'h3c}, 1'b0, 8'h00},
      '{'{sbpci_pkg::OP_WRITE, F_IDE,        REG_COMMAND,    8'hff}, 1'b0, 8'h00},
      '{'{sbpci_pkg::OP_WRITE, F_IDE,        REG_IDE_CHAN,   8'h03}, 1'b0, 8'h00},
      '{'{sbpci_pkg::OP_WRITE, F_IDE,        REG_STATUS_LO,  8'hff}, 1'b0, 8'h00},
      '{'{sbpci_pkg::OP_WRITE, F_IDE,        REG_PROG_IF,    8'h00}, 1'b0, 8'h00},
      '{'{sbpci_pkg::OP_WRITE, F_IDE,        REG_BAR4_LO,    8'hff}, 1'b0, 8'h00},
      '{'{sbpci_pkg::OP_WRITE, F_IDE,        REG_BAR4_HI,    8'hff}, 1'b0, 8'h00},
      '{'{sbpci_pkg::OP_WRITE, F_USB,        REG_COMMAND,    8'hff}, 1'b0, 8'h00},
      '{'{sbpci_pkg::OP_WRITE, F_USB,        REG_STATUS_HI,  8'hff}, 1'b0, 8'h00},
      '{'{sbpci_pkg::OP_WRITE, F_USB,        REG_BAR4_LO,    8'hff}, 1'b0, 8'h00},
      '{'{sbpci_pkg::OP_WRITE, F_POWER,      REG_PM_IOBASE,  8'hff}, 1'b0, 8'h00},
      '{'{sbpci_pkg::OP_WRITE, F_POWER,      REG_PM_CTRL,    8'h80}, 1'b0, 8'h00},
      '{'{sbpci_pkg::OP_WRITE, F_ABSENT_MID, REG_PM_CTRL,    8'hff}, 1'b1, 8'h00},
      '{'{sbpci_pkg::OP_READ,  F_IDE,        REG_STATUS_LO,  8'h00}, 1'b0, 8'h00}
    };
    load_cfg_defaults();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++)
      issue_access(rows[i].acc, rows[i].fixed, rows[i].fixed_rd);

    for (int n = 0; n < RANDOM_ACCESSES; n++) begin
      acc.op = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 11) == 0) acc.fn = 3'($urandom_range(4, 7));
      else acc.fn = 3'($urandom_range(0, 3));
      acc.off = $urandom_range(0, 1) ? pick_hot_offset() : 8'($urandom_range(0, 255));
      case ($urandom_range(0, 7))
        0:       acc.data = 8'h00;
        1:       acc.data = 8'hff;
        default: acc.data = 8'($urandom_range(0, 255));
      endcase
      issue_access(acc, 1'b0, 8'h00);
      // Read back what was just written about a third of the time.
      if (acc.op == sbpci_pkg::OP_WRITE && $urandom_range(0, 2) == 0) begin
        acc.op = sbpci_pkg::OP_READ;
        acc.data = 8'($urandom_range(0, 255));
        issue_access(acc, 1'b0, 8'h00);
        n++;
      end
    end
    in_tvalid <= 1'b0;

    while (cfg_replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d reads and %0d writes, %0d of them to absent functions, %0d reset pulses.",
             reads_sent, writes_sent, absent_sent, pulses_due);
    $display("Checked %0d result words across random stalls and a %0d-cycle receiver hold-off.",
             replies_checked, LONG_HOLD);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
